### src/dlle_pkg.sv
package dlle_pkg;

    localparam int REQ_W    = 3;
    localparam int NODE_W   = 6;
    localparam int SIZE_W   = 7;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_UNLINK     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALREADY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LINKED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                node_linked;
        logic [SIZE_W-1:0]   list_size;
        logic                list_empty;
        logic [NODE_W-1:0]   back_node;
        logic [NODE_W-1:0]   front_node;
    } resp_t;

endpackage

### src/dlle_link_store.sv
module dlle_link_store #(
    parameter int NUM_NODES = 64,
    parameter int AW = 6,
    parameter int DW = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] prev_rd_addr,
    input  logic [AW-1:0] next_rd_addr,
    output logic [DW-1:0] prev_rd_data,
    output logic [DW-1:0] next_rd_data,
    input  logic          prev_wr_en,
    input  logic [AW-1:0] prev_wr_addr,
    input  logic [DW-1:0] prev_wr_data,
    input  logic          next_wr_en,
    input  logic [AW-1:0] next_wr_addr,
    input  logic [DW-1:0] next_wr_data,
    output logic          init_done
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_NODES - 1);

    logic [DW-1:0] prev_mem [NUM_NODES];
    logic [DW-1:0] next_mem [NUM_NODES];

    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          init_done_reg;
    logic          init_done_next;

    logic          prev_we;
    logic [AW-1:0] prev_wa;
    logic [DW-1:0] prev_wd;
    logic          next_we;
    logic [AW-1:0] next_wa;
    logic [DW-1:0] next_wd;

    // Until the sweep is over, every slot is written to point to itself.
    always_comb begin
        clr_cnt_next   = clr_cnt_reg;
        init_done_next = init_done_reg;
        if (!init_done_reg) begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == LAST_ADDR) begin
                init_done_next = 1'b1;
            end
        end
    end

    always_comb begin
        if (!init_done_reg) begin
            prev_we = 1'b1;
            prev_wa = clr_cnt_reg;
            prev_wd = DW'(clr_cnt_reg);
            next_we = 1'b1;
            next_wa = clr_cnt_reg;
            next_wd = DW'(clr_cnt_reg);
        end else begin
            prev_we = prev_wr_en;
            prev_wa = prev_wr_addr;
            prev_wd = prev_wr_data;
            next_we = next_wr_en;
            next_wa = next_wr_addr;
            next_wd = next_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            init_done_reg <= 1'b0;
        end else begin
            clr_cnt_reg   <= clr_cnt_next;
            init_done_reg <= init_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (rd_en) begin
            prev_rd_data <= prev_mem[prev_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (rd_en) begin
            next_rd_data <= next_mem[next_rd_addr];
        end
    end

    assign init_done = init_done_reg;

endmodule

### src/doubly_linked_list_engine.sv
// Circular doubly linked list over NUM_NODES node slots and a sentinel. Each request on the
// slave side (operation code in s_tuser, node slot in s_tdata) yields exactly one response
// transfer on the master side with the front, back, emptiness, size, the node's link state
// and a status. A request passes through these steps before the next one is taken: the
// synchronous read of the node's links, a step in which the node's own entries are written,
// one in which its neighbours' entries are written, and one to load the response register;
// each link memory has one read and one write port. The next request is taken while a
// response still waits on m_tready, but its own response then waits until that transfer.
// After reset the link memories are swept over all NUM_NODES slots, during which s_tready
// stays low.
module doubly_linked_list_engine
    import dlle_pkg::*;
#(
    parameter int NUM_NODES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // node_id[5:0], zero padding
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // front_node, back_node, list_empty, list_size,
                                   // node_linked, status, zero padding
);

    localparam int NW = $clog2(NUM_NODES);
    localparam int SW = $clog2(NUM_NODES + 1);
    localparam logic [SW-1:0] SENT = SW'(NUM_NODES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LINK  = 2'd1;
    localparam logic [1:0] ST_NEIGH = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [SW-1:0] head_reg;
    logic [SW-1:0] head_next;
    logic [SW-1:0] tail_reg;
    logic [SW-1:0] tail_next;
    logic [SW-1:0] count_reg;
    logic [SW-1:0] count_next;

    logic [REQ_W-1:0]  req_reg;
    logic [NODE_W-1:0] node_reg;
    logic [NW-1:0]     node_addr_reg;
    logic              in_range_reg;

    logic              w2_reg;
    logic [SW-1:0]     x_reg;
    logic [SW-1:0]     vx_reg;
    logic [SW-1:0]     y_reg;
    logic [SW-1:0]     vy_reg;
    logic              inc_reg;
    logic              dec_reg;
    logic [STATUS_W-1:0] status_reg;
    logic              linked_reg;

    logic  m_tvalid_reg;
    logic  m_tvalid_next;
    resp_t resp_reg;

    logic          init_done;
    logic          accept;
    logic          list_empty;
    logic [NODE_W-1:0] node_in;
    logic [REQ_W-1:0]  req_in;
    logic          in_range_in;
    logic [NW-1:0] node_addr_in;
    logic [NW-1:0] prev_ra;
    logic [NW-1:0] next_ra;
    logic [SW-1:0] prev_q;
    logic [SW-1:0] next_q;

    logic          prev_we;
    logic [NW-1:0] prev_wa;
    logic [SW-1:0] prev_wd;
    logic          next_we;
    logic [NW-1:0] next_wa;
    logic [SW-1:0] next_wd;

    logic [SW-1:0] node_slot;
    logic          prev_linked;
    logic          next_linked;
    logic          w1_c;
    logic [NW-1:0] w1_addr_c;
    logic [SW-1:0] w1_prev_c;
    logic [SW-1:0] w1_next_c;
    logic          w2_c;
    logic [SW-1:0] x_c;
    logic [SW-1:0] vx_c;
    logic [SW-1:0] y_c;
    logic [SW-1:0] vy_c;
    logic          inc_c;
    logic          dec_c;
    logic [STATUS_W-1:0] status_c;
    logic          linked_c;

    assign node_in      = s_tdata[NODE_W-1:0];
    assign req_in       = s_tuser;
    assign s_tready     = (state_reg == ST_IDLE) && init_done;
    assign accept       = s_tvalid && s_tready;
    assign list_empty   = (head_reg == SENT);
    assign in_range_in  = (32'(node_in) < NUM_NODES);
    assign node_addr_in = in_range_in ? NW'(node_in) : '0;

    always_comb begin
        prev_ra = node_addr_in;
        next_ra = node_addr_in;
        if (req_in == REQ_POP_BACK && !list_empty) begin
            prev_ra = NW'(tail_reg);
        end
        if (req_in == REQ_POP_FRONT && !list_empty) begin
            next_ra = NW'(head_reg);
        end
    end

    dlle_link_store #(
        .NUM_NODES (NUM_NODES),
        .AW        (NW),
        .DW        (SW)
    ) u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_en        (accept),
        .prev_rd_addr (prev_ra),
        .next_rd_addr (next_ra),
        .prev_rd_data (prev_q),
        .next_rd_data (next_q),
        .prev_wr_en   (prev_we),
        .prev_wr_addr (prev_wa),
        .prev_wr_data (prev_wd),
        .next_wr_en   (next_we),
        .next_wr_addr (next_wa),
        .next_wr_data (next_wd),
        .init_done    (init_done)
    );

    // A slot is linked when its links do not point back to itself.
    assign node_slot   = SW'(node_reg);
    assign prev_linked = in_range_reg && (prev_q != node_slot);
    assign next_linked = in_range_reg && (next_q != node_slot);

    always_comb begin
        status_c  = STATUS_OK;
        linked_c  = 1'b0;
        w1_c      = 1'b0;
        w1_addr_c = node_addr_reg;
        w1_prev_c = node_slot;
        w1_next_c = node_slot;
        w2_c      = 1'b0;
        x_c       = SENT;
        vx_c      = SENT;
        y_c       = SENT;
        vy_c      = SENT;
        inc_c     = 1'b0;
        dec_c     = 1'b0;
        unique case (req_reg)
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                linked_c = in_range_reg;
                if (!in_range_reg) begin
                    status_c = STATUS_NOT_LINKED;
                end else if (prev_linked) begin
                    status_c = STATUS_ALREADY;
                end else begin
                    w1_c  = 1'b1;
                    w2_c  = 1'b1;
                    inc_c = 1'b1;
                    vx_c  = node_slot;
                    vy_c  = node_slot;
                    if (req_reg == REQ_PUSH_BACK) begin
                        w1_prev_c = tail_reg;
                        w1_next_c = SENT;
                        x_c       = tail_reg;
                        y_c       = SENT;
                    end else begin
                        w1_prev_c = SENT;
                        w1_next_c = head_reg;
                        x_c       = SENT;
                        y_c       = head_reg;
                    end
                end
            end
            REQ_POP_BACK: begin
                if (list_empty) begin
                    status_c = STATUS_EMPTY;
                    linked_c = next_linked;
                end else begin
                    linked_c  = next_linked && (node_slot != tail_reg);
                    w1_c      = 1'b1;
                    w1_addr_c = NW'(tail_reg);
                    w1_prev_c = tail_reg;
                    w1_next_c = tail_reg;
                    w2_c      = 1'b1;
                    dec_c     = 1'b1;
                    x_c       = prev_q;
                    vx_c      = SENT;
                    y_c       = SENT;
                    vy_c      = prev_q;
                end
            end
            REQ_POP_FRONT: begin
                if (list_empty) begin
                    status_c = STATUS_EMPTY;
                    linked_c = prev_linked;
                end else begin
                    linked_c  = prev_linked && (node_slot != head_reg);
                    w1_c      = 1'b1;
                    w1_addr_c = NW'(head_reg);
                    w1_prev_c = head_reg;
                    w1_next_c = head_reg;
                    w2_c      = 1'b1;
                    dec_c     = 1'b1;
                    x_c       = SENT;
                    vx_c      = next_q;
                    y_c       = next_q;
                    vy_c      = SENT;
                end
            end
            REQ_UNLINK: begin
                if (!prev_linked) begin
                    status_c = STATUS_NOT_LINKED;
                end else begin
                    w1_c  = 1'b1;
                    w2_c  = 1'b1;
                    dec_c = 1'b1;
                    x_c   = prev_q;
                    vx_c  = next_q;
                    y_c   = next_q;
                    vy_c  = prev_q;
                end
            end
            default: begin
                linked_c = prev_linked;
            end
        endcase
    end

    // The sentinel's links live in head_reg and tail_reg rather than in the memories.
    always_comb begin
        prev_we = 1'b0;
        prev_wa = w1_addr_c;
        prev_wd = w1_prev_c;
        next_we = 1'b0;
        next_wa = w1_addr_c;
        next_wd = w1_next_c;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (state_reg == ST_LINK) begin
            prev_we = w1_c;
            next_we = w1_c;
        end else if (state_reg == ST_NEIGH && w2_reg) begin
            prev_wa = NW'(y_reg);
            prev_wd = vy_reg;
            next_wa = NW'(x_reg);
            next_wd = vx_reg;
            if (x_reg == SENT) begin
                head_next = vx_reg;
            end else begin
                next_we = 1'b1;
            end
            if (y_reg == SENT) begin
                tail_next = vy_reg;
            end else begin
                prev_we = 1'b1;
            end
            if (inc_reg) begin
                count_next = count_reg + SW'(1);
            end else if (dec_reg) begin
                count_next = count_reg - SW'(1);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                state_next = ST_NEIGH;
            end
            ST_NEIGH: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= SENT;
            tail_reg     <= SENT;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg       <= req_in;
            node_reg      <= node_in;
            node_addr_reg <= node_addr_in;
            in_range_reg  <= in_range_in;
        end
        if (state_reg == ST_LINK) begin
            w2_reg     <= w2_c;
            x_reg      <= x_c;
            vx_reg     <= vx_c;
            y_reg      <= y_c;
            vy_reg     <= vy_c;
            inc_reg    <= inc_c;
            dec_reg    <= dec_c;
            status_reg <= status_c;
            linked_reg <= linked_c;
        end
        if (state_reg == ST_RESP && (!m_tvalid_reg || m_tready)) begin
            resp_reg.front_node  <= list_empty ? '0 : NODE_W'(head_reg);
            resp_reg.back_node   <= list_empty ? '0 : NODE_W'(tail_reg);
            resp_reg.list_empty  <= list_empty;
            resp_reg.list_size   <= SIZE_W'(count_reg);
            resp_reg.node_linked <= linked_reg;
            resp_reg.status      <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, resp_reg};

    a_count_matches_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) == (head_reg == SENT))
        else $error("Node count disagrees with the sentinel's front link.");

    a_head_tail_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == SENT) == (tail_reg == SENT))
        else $error("Front and back links disagree on emptiness.");

    a_request_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> ##3 (state_reg == ST_RESP))
        else $error("A request did not reach the response step on time.");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && resp_reg.status == STATUS_EMPTY) |-> resp_reg.list_empty)
        else $error("An empty-list status was given for a non-empty list.");

endmodule
